// ===== hw/rtl/ycbbgr_pkg.sv =====
// ----------------------------------------------------------------------------
// ycbbgr_pkg
// Shared constants, stage payload types and the clamp helper of the YCbCr to BGRX
// pixel pipeline.
// ----------------------------------------------------------------------------
package ycbbgr_pkg;

  // Channel sample width
  localparam int unsigned PIX_W  = 8;
  // Signed width of a coefficient product (covers the green dot product too)
  localparam int unsigned PROD_W = 25;
  // Signed width of a luma-plus-offset channel sum before the clamp
  localparam int unsigned SUM_W  = 12;
  // Fraction bits of the 16-bit fixed point coefficients
  localparam int unsigned FRAC_W = 16;

  localparam logic signed [15:0] COEF_B_CB = -16'sh3A5E;
  localparam logic signed [15:0] COEF_R_CR = 16'sh66E9;
  localparam logic signed [15:0] COEF_G_CB = -16'sh581A;
  localparam logic signed [15:0] COEF_G_CR = 16'sh492E;

  localparam logic signed [PROD_W-1:0] G_ROUND    = PROD_W'(32'sh8000);
  localparam logic [PIX_W-1:0]         FILLER_VAL = 8'hFF;

  // Stage 1: luma and centered chroma
  typedef struct packed {
    logic        [PIX_W-1:0] luma;
    logic signed [PIX_W-1:0] cb;
    logic signed [PIX_W-1:0] cr;
  } ctr_t;

  // Stage 2: coefficient products
  typedef struct packed {
    logic        [PIX_W-1:0]  luma;
    logic signed [PIX_W-1:0]  cb;
    logic signed [PIX_W-1:0]  cr;
    logic signed [PROD_W-1:0] pb;
    logic signed [PROD_W-1:0] pr;
    logic signed [PROD_W-1:0] gcb;
    logic signed [PROD_W-1:0] gcr;
  } prod_t;

  // Stage 3: unclamped channel sums
  typedef struct packed {
    logic signed [SUM_W-1:0] b;
    logic signed [SUM_W-1:0] g;
    logic signed [SUM_W-1:0] r;
  } sum_t;

  // Stage 4: final pixel
  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pix_t;

  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SUM_W'({PIX_W{1'b1}}))) begin
      res = '1;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/ycbbgr_if.sv =====
// ----------------------------------------------------------------------------
// ycbbgr_if
// Valid/ready channels carrying YCbCr input beats and BGRX output beats.
// ----------------------------------------------------------------------------
interface ycbbgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, luma, chroma_blue, chroma_red, input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, output ready);
endinterface

interface ycbbgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] filler;

  modport source (output valid, blue, green, red, filler, input ready);
  modport sink   (input valid, blue, green, red, filler, output ready);
endinterface

// ===== hw/rtl/ycbbgr_center.sv =====
// ----------------------------------------------------------------------------
// ycbbgr_center
// Stage 1: register luma and remove the 128 offset from both chroma samples.
// ----------------------------------------------------------------------------
module ycbbgr_center (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [7:0]              luma_i,
  input  logic [7:0]              cb_i,
  input  logic [7:0]              cr_i,
  output logic                    valid_o,
  output ycbbgr_pkg::ctr_t        data_o
);
  import ycbbgr_pkg::*;

  logic valid_q;
  ctr_t data_d, data_q;

  // x - 128 on a byte is the byte with its top bit flipped, read as signed
  always_comb begin
    data_d.luma = luma_i;
    data_d.cb   = $signed({~cb_i[7], cb_i[6:0]});
    data_d.cr   = $signed({~cr_i[7], cr_i[6:0]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/ycbbgr_mult.sv =====
// ----------------------------------------------------------------------------
// ycbbgr_mult
// Stage 2: the four chroma-by-coefficient products.
// ----------------------------------------------------------------------------
module ycbbgr_mult (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ycbbgr_pkg::ctr_t  data_i,
  output logic              valid_o,
  output ycbbgr_pkg::prod_t data_o
);
  import ycbbgr_pkg::*;

  logic  valid_q;
  prod_t data_d, data_q;
  logic signed [PIX_W:0] two_cb, two_cr;

  always_comb begin
    two_cb      = {data_i.cb, 1'b0};
    two_cr      = {data_i.cr, 1'b0};
    data_d.luma = data_i.luma;
    data_d.cb   = data_i.cb;
    data_d.cr   = data_i.cr;
    data_d.pb   = PROD_W'(two_cb) * PROD_W'(COEF_B_CB);
    data_d.pr   = PROD_W'(two_cr) * PROD_W'(COEF_R_CR);
    data_d.gcb  = PROD_W'(data_i.cb) * PROD_W'(COEF_G_CB);
    data_d.gcr  = PROD_W'(data_i.cr) * PROD_W'(COEF_G_CR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/ycbbgr_sum.sv =====
// ----------------------------------------------------------------------------
// ycbbgr_sum
// Stage 3: take the high halves, round, and add the offsets to luma.
// ----------------------------------------------------------------------------
module ycbbgr_sum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  ycbbgr_pkg::prod_t data_i,
  output logic              valid_o,
  output ycbbgr_pkg::sum_t  data_o
);
  import ycbbgr_pkg::*;

  logic valid_q;
  sum_t data_d, data_q;
  logic signed [SUM_W-1:0]  hi_b, hi_r, rh_b, rh_r, luma_s, cb_s, cr_s, gy;
  logic signed [PROD_W-1:0] g_acc;

  always_comb begin
    luma_s = $signed(SUM_W'(data_i.luma));
    cb_s   = SUM_W'(data_i.cb);
    cr_s   = SUM_W'(data_i.cr);
    // arithmetic shifts floor, matching the fixed point definition
    hi_b   = SUM_W'(data_i.pb >>> FRAC_W);
    hi_r   = SUM_W'(data_i.pr >>> FRAC_W);
    rh_b   = (hi_b + SUM_W'(1)) >>> 1;
    rh_r   = (hi_r + SUM_W'(1)) >>> 1;
    g_acc  = data_i.gcb + data_i.gcr + G_ROUND;
    gy     = SUM_W'(g_acc >>> FRAC_W) - cr_s;
    data_d.b = luma_s + rh_b + (cb_s <<< 1);
    data_d.r = luma_s + rh_r + cr_s;
    data_d.g = luma_s + gy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/ycbbgr_clamp.sv =====
// ----------------------------------------------------------------------------
// ycbbgr_clamp
// Stage 4: saturate each channel to a byte; this is the output register.
// ----------------------------------------------------------------------------
module ycbbgr_clamp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ycbbgr_pkg::sum_t data_i,
  output logic             valid_o,
  output ycbbgr_pkg::pix_t data_o
);
  import ycbbgr_pkg::*;

  logic valid_q;
  pix_t data_d, data_q;

  always_comb begin
    data_d.blue  = clamp_byte(data_i.b);
    data_d.green = clamp_byte(data_i.g);
    data_d.red   = clamp_byte(data_i.r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// ===== hw/rtl/ycbcr_to_bgrx_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// ycbcr_to_bgrx_pixel_unit
// Full-range YCbCr to BGRX pixel converter, four register stages.
// ----------------------------------------------------------------------------
// One pixel beat in, one BGRX beat out, one pixel per clock sustained while
// the sink keeps ready high. A pixel passes through chroma centering, the
// coefficient multipliers, rounding and summing, then the clamp into the
// output register. The four stages advance together; when the output beat
// is held by the sink the whole pipeline freezes and input ready drops in
// the same cycle, so nothing is lost or repeated. The fourth byte is 0xFF.
module ycbcr_to_bgrx_pixel_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  ycbbgr_in_if.sink     pix_in,
  ycbbgr_out_if.source  pix_out
);
  import ycbbgr_pkg::*;

  logic  en;
  logic  st1_valid, st2_valid, st3_valid, st4_valid;
  ctr_t  st1_data;
  prod_t st2_data;
  sum_t  st3_data;
  pix_t  st4_data;

  // advance whenever the output slot is empty or being taken
  assign en           = !st4_valid || pix_out.ready;
  assign pix_in.ready = en;

  ycbbgr_center u_center (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pix_in.valid),
    .luma_i  (pix_in.luma),
    .cb_i    (pix_in.chroma_blue),
    .cr_i    (pix_in.chroma_red),
    .valid_o (st1_valid),
    .data_o  (st1_data)
  );

  ycbbgr_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st1_valid),
    .data_i  (st1_data),
    .valid_o (st2_valid),
    .data_o  (st2_data)
  );

  ycbbgr_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st2_valid),
    .data_i  (st2_data),
    .valid_o (st3_valid),
    .data_o  (st3_data)
  );

  ycbbgr_clamp u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (st3_valid),
    .data_i  (st3_data),
    .valid_o (st4_valid),
    .data_o  (st4_data)
  );

  assign pix_out.valid  = st4_valid;
  assign pix_out.blue   = st4_data.blue;
  assign pix_out.green  = st4_data.green;
  assign pix_out.red    = st4_data.red;
  assign pix_out.filler = FILLER_VAL;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_in.valid && pix_in.ready) |=> st1_valid)
    else $error("accepted beat did not enter stage 1");

  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(st2_valid) && $stable(st3_valid) && $stable(st3_data)))
    else $error("pipeline moved while stalled");

  a_last_stage_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && st3_valid) |=> st4_valid)
    else $error("stage 3 beat dropped on the way to the output");
endmodule
